FILE: rtl/sstf_disk_request_scheduler_defines.svh
// Assertion macros for the request scheduler.
`ifndef SSTF_DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_DEFINES_SVH

`ifndef SYNTH
`define SSTF_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("sstf assertion failed");
`define SSTF_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("sstf assertion failed");
`else
`define SSTF_ASSERT_IMP(lbl, a, b)
`define SSTF_ASSERT_NXT(lbl, a, b)
`endif

`endif

FILE: rtl/sstf_pkg.sv
package sstf_pkg;

  localparam int unsigned POS_W = 16;
  localparam int unsigned SUM_W = 22;
  localparam logic [SUM_W-1:0] TOTAL_MAX = {SUM_W{1'b1}};

  // candidate rippling down the cell row
  typedef struct packed {
    logic             go;
    logic             found;
    logic [POS_W-1:0] seek;
    logic [POS_W-1:0] pos;
  } cand_t;

  // shared controls broadcast to every cell
  typedef struct packed {
    logic             clear;
    logic [POS_W-1:0] head;
    logic [POS_W-1:0] wr_pos;
  } cell_ctl_t;

endpackage

FILE: rtl/sstf_disk_request_scheduler.sv
// After the last request of a batch, each result comes from a scan that ripples through
// the cell registers; the winner is latched, then registered out when the output is free.
// Each result is one nearest-distance candidate ripple through the row of cells.
// Requests are taken only between batches; config writes are taken at any time.
// Reset (synchronous, rst_n low) clears the queue, counters and start position.
`include "sstf_disk_request_scheduler_defines.svh"

module sstf_disk_request_scheduler import sstf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,     // start_position
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // request_position
  input  logic        in_tlast,     // last_request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,    // served_position, seek_distance, total_movement, pad
  output logic        out_tlast     // last_served
);

  localparam int unsigned IDXW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [POS_W-1:0] start_pos_r;
  logic [POS_W-1:0] head_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNTW-1:0]  cnt_r;
  logic [CNTW-1:0]  srv_r;
  logic             go_r;
  logic [POS_W-1:0] win_pos_r;
  logic [POS_W-1:0] win_dist_r;
  logic [IDXW-1:0]  win_idx_r;

  logic             out_valid_r;
  logic [POS_W-1:0] out_pos_r;
  logic [POS_W-1:0] out_dist_r;
  logic [SUM_W-1:0] out_sum_r;
  logic             out_last_r;

  logic             in_fire;
  logic             emit_fire;
  logic             batch_end;
  logic             store_ok;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_sat;

  cell_ctl_t        ctl;
  cand_t            cand_w [QUEUE_DEPTH+1];
  logic [IDXW-1:0]  idx_w  [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH:0] go_vec;
  logic [QUEUE_DEPTH-1:0] wr_sel;
  logic [QUEUE_DEPTH-1:0] mark_sel;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign store_ok  = (cnt_r != CNTW'(QUEUE_DEPTH));
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign batch_end = (srv_r + CNTW'(1)) == cnt_r;

  assign sum_ext = {1'b0, sum_r} + {{(SUM_W + 1 - POS_W){1'b0}}, win_dist_r};
  assign sum_sat = sum_ext[SUM_W] ? TOTAL_MAX : sum_ext[SUM_W-1:0];

  assign ctl.clear  = emit_fire && batch_end;
  assign ctl.head   = head_r;
  assign ctl.wr_pos = in_tdata;

  assign cand_w[0] = '{go: go_r, found: 1'b0, seek: '0, pos: '0};
  assign idx_w[0]  = '0;

  genvar k;
  generate
    for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      assign wr_sel[k]   = in_fire && store_ok && (cnt_r[IDXW-1:0] == IDXW'(k));
      assign mark_sel[k] = emit_fire && (win_idx_r == IDXW'(k));
      assign go_vec[k]   = cand_w[k].go;
      sstf_cell #(
        .IDXW     (IDXW),
        .CELL_IDX (k)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .wr_en    (wr_sel[k]),
        .mark_en  (mark_sel[k]),
        .cand_in  (cand_w[k]),
        .idx_in   (idx_w[k]),
        .cand_out (cand_w[k+1]),
        .idx_out  (idx_w[k+1])
      );
    end
  endgenerate
  assign go_vec[QUEUE_DEPTH] = cand_w[QUEUE_DEPTH].go;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_tlast) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cand_w[QUEUE_DEPTH].go) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_nxt = batch_end ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_pos_r <= '0;
      cnt_r       <= '0;
      srv_r       <= '0;
      sum_r       <= '0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= (in_fire && in_tlast) || (emit_fire && !batch_end);
      if (cfg_valid && cfg_ready) begin
        start_pos_r <= cfg_data;
      end
      if (in_fire) begin
        if (store_ok) begin
          cnt_r <= cnt_r + CNTW'(1);
        end
        if (in_tlast) begin
          srv_r <= '0;
          sum_r <= '0;
        end
      end else if (emit_fire) begin
        srv_r <= srv_r + CNTW'(1);
        if (batch_end) begin
          cnt_r <= '0;
          sum_r <= '0;
        end else begin
          sum_r <= sum_sat;
        end
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      head_r <= start_pos_r;
    end else if (emit_fire) begin
      head_r <= win_pos_r;
    end
    if ((state_r == ST_SCAN) && cand_w[QUEUE_DEPTH].go) begin
      win_pos_r  <= cand_w[QUEUE_DEPTH].pos;
      win_dist_r <= cand_w[QUEUE_DEPTH].seek;
      win_idx_r  <= idx_w[QUEUE_DEPTH];
    end
    if (emit_fire) begin
      out_pos_r  <= win_pos_r;
      out_dist_r <= win_dist_r;
      out_sum_r  <= sum_sat;
      out_last_r <= batch_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_sum_r, out_dist_r, out_pos_r};
  assign out_tlast  = out_last_r;

  `SSTF_ASSERT_IMP(a_one_scan, 1'b1, $onehot0(go_vec))
  `SSTF_ASSERT_IMP(a_end_in_scan, cand_w[QUEUE_DEPTH].go, state_r == ST_SCAN)
  `SSTF_ASSERT_IMP(a_winner_found, cand_w[QUEUE_DEPTH].go, cand_w[QUEUE_DEPTH].found)
  `SSTF_ASSERT_NXT(a_batch_clear, emit_fire && batch_end, cnt_r == '0)

endmodule

FILE: rtl/sstf_cell.sv
module sstf_cell import sstf_pkg::*; #(
  parameter int unsigned IDXW     = 5,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cell_ctl_t       ctl,
  input  logic            wr_en,
  input  logic            mark_en,
  input  cand_t           cand_in,
  input  logic [IDXW-1:0] idx_in,
  output cand_t           cand_out,
  output logic [IDXW-1:0] idx_out
);

  logic             valid_r;
  logic             served_r;
  logic [POS_W-1:0] pos_r;
  cand_t            cand_r;
  logic [IDXW-1:0]  idx_r;
  logic [POS_W-1:0] d;
  logic             take;

  assign d    = (ctl.head > pos_r) ? (ctl.head - pos_r) : (pos_r - ctl.head);
  assign take = valid_r && !served_r && (!cand_in.found || (d < cand_in.seek));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      served_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r  <= 1'b0;
      served_r <= 1'b0;
    end else if (wr_en) begin
      valid_r  <= 1'b1;
      served_r <= 1'b0;
    end else if (mark_en) begin
      served_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_r <= ctl.wr_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
      idx_r  <= '0;
    end else begin
      cand_r.go <= cand_in.go;
      if (take) begin
        cand_r.found <= 1'b1;
        cand_r.seek  <= d;
        cand_r.pos   <= pos_r;
        idx_r        <= IDXW'(CELL_IDX);
      end else begin
        cand_r.found <= cand_in.found;
        cand_r.seek  <= cand_in.seek;
        cand_r.pos   <= cand_in.pos;
        idx_r        <= idx_in;
      end
    end
  end

  assign cand_out = cand_r;
  assign idx_out  = idx_r;

endmodule
